/* sv/stg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stg_pkg: shared types and constants for the sine tone generator
// Field widths, configuration defaults, register indexes, the sequencer
// states and the CORDIC arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package stg_pkg;

	localparam int TONE_W   = 17;
	localparam int RATE_W   = 18;
	localparam int PH_W     = 18;
	localparam int POS_W    = 32;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = RATE_W;
	localparam int IDX_W    = 1;

	localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
	localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(192000);
	localparam logic [TONE_W-1:0] TONE_RESET = TONE_W'(639);
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

	localparam logic [IDX_W-1:0] REG_TONE_HZ     = 1'b0;
	localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEK,
		ST_REDUCE,
		ST_ANGLE,
		ST_ROUND,
		ST_CORDIC,
		ST_EMIT
	} state_t;

	localparam int TABLE_LEN  = 24;
	localparam int ATAN_W     = 30;
	localparam int XW         = 34;
	localparam int ZW         = 33;
	localparam int FRAC_BITS  = 16;
	localparam int MAG_W      = XW - FRAC_BITS;

	localparam logic signed [XW-1:0] X_START = XW'(64'sd1304025951);
	localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(32767);

	localparam logic [ATAN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41721, 30'd20860,
		30'd10430, 30'd5215, 30'd2607, 30'd1303,
		30'd651, 30'd325, 30'd162, 30'd81
	};

endpackage
`default_nettype wire

/* sv/sine_tone_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_generator: direct digital synthesis sine oscillator
// Keeps the sample position as an exact phase numerator modulo the sample
// rate; a tick word yields one 16-bit sample, a seek word sets the position.
//
//   channel   signals                          direction  moves
//   in        in_valid in_ready kind position  input      one tick or seek word
//   out       out_valid out_ready sample       output     one sample word
//   cfg       cfg_wr_en cfg_index cfg_data     input      register write
//
// tick: sample valid and input ready come together once the word has passed
// the bit-serial phase reduction and angle division, the rounding step and
// the CORDIC step loop
// seek: input ready again once all position bits have gone in, one position
// bit per cycle through the modular accumulator
// reset clears the phase and loads tone 639 Hz at 44100 Hz
// a new word is taken while a sample waits; a stalled sample holds the finish
// ----------------------------------------------------------------------------
module sine_tone_generator #(
	parameter int ANGLE_BITS   = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [stg_pkg::IDX_W-1:0]            cfg_index,
	input  wire logic [stg_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [stg_pkg::POS_W-1:0]            position,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [stg_pkg::SAMPLE_W-1:0]       sample
);

	localparam int RW    = stg_pkg::RATE_W;
	localparam int CNT_W = $clog2((ANGLE_BITS > stg_pkg::POS_W) ? ANGLE_BITS
	                       : stg_pkg::POS_W) + 1;

	stg_pkg::state_t state_q, state_d;

	logic [stg_pkg::TONE_W-1:0]  tone_hz_q;
	logic [RW-1:0]               sample_rate_q;
	logic [RW-1:0]               rate_q;
	logic [stg_pkg::TONE_W-1:0]  hz_q;
	logic [stg_pkg::PH_W-1:0]    phase_q, num_q, rem_q;
	logic [stg_pkg::POS_W-1:0]   shreg_q;
	logic [ANGLE_BITS-1:0]       a_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        out_valid_q;
	logic signed [stg_pkg::SAMPLE_W-1:0] sample_q;

	logic [RW-1:0]               rate_c, lim_c;
	logic [stg_pkg::TONE_W-1:0]  hz_c;
	logic                        accept, emit, cordic_start, cordic_done;
	logic signed [stg_pkg::SAMPLE_W-1:0] cordic_sample;

	logic [RW:0]                 acc, t2, rnd_sum, ph_sum;
	logic                        ge, rnd;
	logic [RW-1:0]               t1, t2r, ph_next;
	logic [ANGLE_BITS-1:0]       a_round;
	logic [31:0]                 angle32;

	// effective rate and tone
	always_comb begin
		if (sample_rate_q < stg_pkg::RATE_MIN) begin
			rate_c = stg_pkg::RATE_MIN;
		end else if (sample_rate_q > stg_pkg::RATE_MAX) begin
			rate_c = stg_pkg::RATE_MAX;
		end else begin
			rate_c = sample_rate_q;
		end
		lim_c = (rate_c - 1'b1) >> 1;
		hz_c  = (RW'(tone_hz_q) < lim_c) ? tone_hz_q : stg_pkg::TONE_W'(lim_c);
	end

	// shared compare-subtract step
	always_comb begin
		acc     = {rem_q, (state_q == stg_pkg::ST_REDUCE) ? shreg_q[stg_pkg::POS_W-1] : 1'b0};
		ge      = acc >= {1'b0, rate_q};
		t1      = ge ? RW'(acc - {1'b0, rate_q}) : acc[RW-1:0];
		t2      = {1'b0, t1} + (shreg_q[stg_pkg::POS_W-1] ? (RW+1)'(hz_q) : '0);
		t2r     = (t2 >= {1'b0, rate_q}) ? RW'(t2 - {1'b0, rate_q}) : t2[RW-1:0];
		rnd_sum = {1'b0, rem_q} + {2'b0, rate_q[RW-1:1]};
		rnd     = rnd_sum >= {1'b0, rate_q};
		a_round = a_q + ANGLE_BITS'(rnd);
		angle32 = 32'(a_round) << (32 - ANGLE_BITS);
		ph_sum  = {1'b0, num_q} + (RW+1)'(hz_q);
		ph_next = (ph_sum >= {1'b0, rate_q}) ? RW'(ph_sum - {1'b0, rate_q})
		          : ph_sum[RW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = kind ? stg_pkg::ST_SEEK : stg_pkg::ST_REDUCE;
				end
			end
			stg_pkg::ST_SEEK: begin
				if (cnt_q == CNT_W'(stg_pkg::POS_W - 1)) state_d = stg_pkg::ST_IDLE;
			end
			stg_pkg::ST_REDUCE: begin
				if (cnt_q == CNT_W'(stg_pkg::PH_W - 1)) state_d = stg_pkg::ST_ANGLE;
			end
			stg_pkg::ST_ANGLE: begin
				if (cnt_q == CNT_W'(ANGLE_BITS - 1)) state_d = stg_pkg::ST_ROUND;
			end
			stg_pkg::ST_ROUND: begin
				state_d = stg_pkg::ST_CORDIC;
			end
			stg_pkg::ST_CORDIC: begin
				if (cordic_done) state_d = stg_pkg::ST_EMIT;
			end
			stg_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = stg_pkg::ST_IDLE;
			end
			default: begin
				state_d = stg_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_ready     = (state_q == stg_pkg::ST_IDLE);
		accept       = in_ready && in_valid;
		cordic_start = (state_q == stg_pkg::ST_ROUND);
		emit         = (state_q == stg_pkg::ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= stg_pkg::ST_IDLE;
			tone_hz_q     <= stg_pkg::TONE_RESET;
			sample_rate_q <= stg_pkg::RATE_RESET;
			phase_q       <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (cfg_wr_en) begin
				case (cfg_index)
					stg_pkg::REG_TONE_HZ:     tone_hz_q     <= cfg_data[stg_pkg::TONE_W-1:0];
					stg_pkg::REG_SAMPLE_RATE: sample_rate_q <= cfg_data[RW-1:0];
					default: ;
				endcase
			end
			if (state_q == stg_pkg::ST_SEEK && state_d == stg_pkg::ST_IDLE) begin
				phase_q <= t2r;
			end else if (emit) begin
				phase_q <= ph_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bit-serial datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			rate_q  <= rate_c;
			hz_q    <= hz_c;
			rem_q   <= '0;
			shreg_q <= kind ? position
			           : stg_pkg::POS_W'(phase_q) << (stg_pkg::POS_W - stg_pkg::PH_W);
		end else begin
			case (state_q)
				stg_pkg::ST_SEEK: begin
					rem_q   <= t2r;
					shreg_q <= shreg_q << 1;
				end
				stg_pkg::ST_REDUCE: begin
					rem_q   <= t1;
					shreg_q <= shreg_q << 1;
					if (state_d != state_q) num_q <= t1;
				end
				stg_pkg::ST_ANGLE: begin
					rem_q <= t1;
					a_q   <= {a_q[ANGLE_BITS-2:0], ge};
				end
				default: ;
			endcase
		end
		if (emit) sample_q <= cordic_sample;
	end

	stg_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (angle32),
		.done   (cordic_done),
		.sample (cordic_sample)
	);

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule
`default_nettype wire

/* sv/stg_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stg_cordic: iterative rotation-mode CORDIC sine
// Resolves one arctangent step per cycle from a 32-bit turn-fraction angle,
// then folds the quadrant and scales the result to a 16-bit sample.
// ----------------------------------------------------------------------------
module stg_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [31:0]                          angle,
	output logic                                      done,
	output logic signed [stg_pkg::SAMPLE_W-1:0]       sample
);

	localparam int STEPS  = (CORDIC_STEPS < stg_pkg::TABLE_LEN) ? CORDIC_STEPS
	                        : stg_pkg::TABLE_LEN;
	localparam int STEP_W = $clog2(stg_pkg::TABLE_LEN);

	logic signed [stg_pkg::XW-1:0] x_q, y_q, xs, ys;
	logic signed [stg_pkg::ZW-1:0] z_q, at;
	logic [1:0]                    quad_q;
	logic [STEP_W-1:0]             step_q;
	logic                          busy_q, done_q;

	logic signed [stg_pkg::XW-1:0]    v;
	logic [stg_pkg::XW-1:0]           mag;
	logic [stg_pkg::MAG_W-1:0]        mag_hi;
	logic [stg_pkg::SAMPLE_W-1:0]     s_abs;
	logic                             neg;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = $signed({{(stg_pkg::ZW - stg_pkg::ATAN_W){1'b0}},
			stg_pkg::ATAN_TURNS[step_q]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= stg_pkg::X_START;
			y_q    <= '0;
			z_q    <= $signed({{(stg_pkg::ZW - 30){1'b0}}, angle[29:0]});
			quad_q <= angle[31:30];
		end else if (busy_q) begin
			if (!z_q[stg_pkg::ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant fold, truncate toward zero, saturate
	always_comb begin
		v      = quad_q[0] ? x_q : y_q;
		neg    = v[stg_pkg::XW-1];
		mag    = neg ? stg_pkg::XW'(-v) : stg_pkg::XW'(v);
		mag_hi = mag[stg_pkg::XW-1:stg_pkg::FRAC_BITS];
		s_abs  = (mag_hi > stg_pkg::MAG_MAX) ? stg_pkg::SAMPLE_W'(stg_pkg::MAG_MAX)
		         : stg_pkg::SAMPLE_W'(mag_hi);
		sample = (neg ^ quad_q[1]) ? $signed(-s_abs) : $signed(s_abs);
		done   = done_q;
	end

endmodule
`default_nettype wire
